// ===== sv/local_range_luma_normalizer_top_defines.svh =====
// ----------------------------------------------------------------------------
// local_range_luma_normalizer_top_defines
// Assertion macros shared by the checker of the luma normalizer.
// ----------------------------------------------------------------------------
`ifndef LOCAL_RANGE_LUMA_NORMALIZER_TOP_DEFINES_SVH
`define LOCAL_RANGE_LUMA_NORMALIZER_TOP_DEFINES_SVH

// generic clocked property, disabled while reset is asserted
`define LRLN_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lrln: assertion failed");

// a stalled transfer keeps valid high and its payload unchanged
`define LRLN_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, pay) \
  `LRLN_ASSERT(lbl, clk, rst_n, (vld) && !(rdy) |=> (vld) && $stable(pay))

`endif

// ===== sv/lrln_pkg.sv =====
// ----------------------------------------------------------------------------
// lrln_pkg
// Types, constants and helpers of the local range luma normalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package lrln_pkg;

  // pixel format
  localparam int PIXEL_BITS = 16;
  localparam int SVAL_BITS  = PIXEL_BITS + 2;
  localparam int NUM_BITS   = 2 * PIXEL_BITS;

  localparam logic [PIXEL_BITS-1:0] FULL_SCALE      = '1;
  localparam logic [PIXEL_BITS-1:0] MIN_RANGE_RESET = PIXEL_BITS'(6553);

  // stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = 4 * PIXEL_BITS;
  localparam int OUT_TDATA_W = ((PIXEL_BITS + 1 + 7) / 8) * 8;

  // register port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] ADDR_MIN_RANGE = '0;

  // divider pipeline: quotient bits resolved per stage
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES         = PIXEL_BITS / DIV_BITS_PER_STAGE;

  typedef logic [PIXEL_BITS-1:0]        pix_t;
  typedef logic signed [SVAL_BITS-1:0]  sval_t;

  // how the final luma is formed
  typedef enum logic [1:0] {
    RES_QUOT = 2'd0,
    RES_ZERO = 2'd1,
    RES_FULL = 2'd2
  } res_kind_e;

  typedef struct packed {
    pix_t middle;
    pix_t env_min;
    pix_t env_max;
    pix_t luma;
  } pix_in_t;

  // final result of one pixel
  typedef struct packed {
    logic clipped;
    pix_t luma_out;
  } pix_out_t;

  // partial remainder, numerator bits shifting out / quotient bits shifting in
  typedef struct packed {
    pix_t      rem;
    pix_t      work;
    pix_t      den;
    res_kind_e kind;
  } div_t;

  // zero extend a pixel into the signed working width
  function automatic sval_t to_sval(input pix_t v);
    return sval_t'({{(SVAL_BITS-PIXEL_BITS){1'b0}}, v});
  endfunction

endpackage

`default_nettype wire

// ===== sv/lrln_prep.sv =====
// ----------------------------------------------------------------------------
// lrln_prep
// Envelope mirroring, range widening and quotient setup, four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module lrln_prep (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lrln_pkg::pix_t    min_range_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lrln_pkg::pix_in_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lrln_pkg::div_t    out_data_o
);
  import lrln_pkg::*;

  logic s1_ready, s2_ready, s3_ready, s4_ready;
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;

  // stage 1 registers
  pix_t s1_luma_q, s1_lo_q, s1_hi_q;
  // stage 2 registers
  pix_t s2_luma_q, s2_lo_q, s2_range_q, s2_centre_q;
  logic s2_widen_q;
  // stage 3 registers
  pix_t s3_luma_q, s3_lo_q, s3_range_q;
  // stage 4 register
  div_t s4_data_q;

  // per-stage ready lets bubbles collapse while the far end stalls
  assign s4_ready   = !s4_valid_q || out_ready_i;
  assign s3_ready   = !s3_valid_q || s4_ready;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  // stage 1: mirror the narrower envelope side about the middle
  sval_t env_hi, env_lo, twice_mid, skew, mir_lo, mir_hi;
  pix_t  s1_lo_d, s1_hi_d;

  always_comb begin
    env_hi    = to_sval(in_data_i.env_max);
    env_lo    = to_sval(in_data_i.env_min);
    twice_mid = to_sval(in_data_i.middle) + to_sval(in_data_i.middle);
    skew      = env_hi + env_lo - twice_mid;
    mir_lo    = twice_mid - env_hi;
    mir_hi    = twice_mid - env_lo;
    s1_lo_d   = in_data_i.env_min;
    s1_hi_d   = in_data_i.env_max;
    if (skew > 0) begin
      s1_lo_d = (mir_lo < 0) ? '0 : mir_lo[PIXEL_BITS-1:0];
    end else if (skew < 0) begin
      s1_hi_d = (mir_hi > to_sval(FULL_SCALE)) ? FULL_SCALE : mir_hi[PIXEL_BITS-1:0];
    end
  end

  // stage 2: range, centre and the widening decision
  sval_t raw_range;
  pix_t  s2_range_d, s2_centre_d;

  always_comb begin
    raw_range   = to_sval(s1_hi_q) - to_sval(s1_lo_q);
    s2_range_d  = (raw_range < 0) ? '0 : raw_range[PIXEL_BITS-1:0];
    s2_centre_d = s1_lo_q + (s2_range_d >> 1);
  end

  // stage 3: widen around the centre and push back inside full scale
  pix_t  half_min;
  sval_t wide_lo, wide_hi, pushed_lo;
  pix_t  s3_lo_d, s3_range_d;

  always_comb begin
    half_min   = min_range_i >> 1;
    wide_lo    = to_sval(s2_centre_q) - to_sval(half_min);
    wide_hi    = to_sval(s2_centre_q) + to_sval(half_min);
    pushed_lo  = wide_lo - (wide_hi - to_sval(FULL_SCALE));
    s3_lo_d    = s2_lo_q;
    s3_range_d = s2_range_q;
    if (s2_widen_q) begin
      s3_range_d = min_range_i;
      if (wide_lo < 0) begin
        s3_lo_d = '0;
      end else if (wide_hi > to_sval(FULL_SCALE)) begin
        s3_lo_d = pushed_lo[PIXEL_BITS-1:0];
      end else begin
        s3_lo_d = wide_lo[PIXEL_BITS-1:0];
      end
    end
  end

  // stage 4: numerator (luma - lo) * full scale and result kind
  sval_t                diff_s;
  pix_t                 diff;
  logic [NUM_BITS-1:0]  num, bound;
  div_t                 s4_data_d;

  always_comb begin
    diff_s = to_sval(s3_luma_q) - to_sval(s3_lo_q);
    diff   = diff_s[PIXEL_BITS-1:0];
    num    = {diff, {PIXEL_BITS{1'b0}}} - {{PIXEL_BITS{1'b0}}, diff};
    bound  = {s3_range_q, {PIXEL_BITS{1'b0}}};
    s4_data_d.rem  = num[NUM_BITS-1:PIXEL_BITS];
    s4_data_d.work = num[PIXEL_BITS-1:0];
    s4_data_d.den  = s3_range_q;
    if (s3_range_q == '0) begin
      s4_data_d.kind = RES_FULL;
    end else if (diff_s <= 0) begin
      s4_data_d.kind = RES_ZERO;
    end else if (num >= bound) begin
      s4_data_d.kind = RES_FULL;
    end else begin
      s4_data_d.kind = RES_QUOT;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= in_valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (s3_ready) s3_valid_q <= s2_valid_q;
      if (s4_ready) s4_valid_q <= s3_valid_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      s1_luma_q <= in_data_i.luma;
      s1_lo_q   <= s1_lo_d;
      s1_hi_q   <= s1_hi_d;
    end
    if (s2_ready) begin
      s2_luma_q   <= s1_luma_q;
      s2_lo_q     <= s1_lo_q;
      s2_range_q  <= s2_range_d;
      s2_centre_q <= s2_centre_d;
      s2_widen_q  <= s2_range_d < min_range_i;
    end
    if (s3_ready) begin
      s3_luma_q  <= s2_luma_q;
      s3_lo_q    <= s3_lo_d;
      s3_range_q <= s3_range_d;
    end
    if (s4_ready) begin
      s4_data_q <= s4_data_d;
    end
  end

  assign out_valid_o = s4_valid_q;
  assign out_data_o  = s4_data_q;

endmodule

`default_nettype wire

// ===== sv/lrln_div_stage.sv =====
// ----------------------------------------------------------------------------
// lrln_div_stage
// One registered stage of the restoring divider, two quotient bits a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lrln_div_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lrln_pkg::div_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output lrln_pkg::div_t out_data_o
);
  import lrln_pkg::*;

  logic              valid_q;
  div_t              data_q, data_d;
  logic [PIXEL_BITS:0] trial;

  assign in_ready_o = !valid_q || out_ready_i;

  // shift a numerator bit into the remainder and subtract when it fits, once per quotient bit of the stage
  always_comb begin
    data_d = in_data_i;
    trial  = '0;
    for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
      trial       = {data_d.rem, data_d.work[PIXEL_BITS-1]};
      data_d.work = data_d.work << 1;
      if (trial >= {1'b0, data_d.den}) begin
        trial          = trial - {1'b0, data_d.den};
        data_d.work[0] = 1'b1;
      end
      data_d.rem = trial[PIXEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// ===== sv/local_range_luma_normalizer_top.sv =====
// ----------------------------------------------------------------------------
// local_range_luma_normalizer_top
// Per-pixel local range normalization of luma for a min/max tone mapper.
// ----------------------------------------------------------------------------
// One pixel is taken per clock and one result leaves per clock unless the
// output stalls. Four stages mirror and widen the envelope and set up the
// numerator, eight stages of a pipelined restoring divider (two quotient bits
// per stage) form (luma - min) * 65535 / range, and one output register holds
// the result. Each stage stalls only when it is full and the stage after it
// stalls, so while results wait the input keeps taking pixels until every
// stage is full. min_range is to be written over the register port only while
// no pixel is in flight (not enforced); there is no start-up clearing pass.
`default_nettype none

module local_range_luma_normalizer_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // pixel input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // luma_in [15:0], envelope_max [31:16], envelope_min [47:32], middle_level [63:48]
  input  logic [lrln_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // luma_out [15:0], clipped [16], zero padding [23:17]
  output logic [lrln_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lrln_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [lrln_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [lrln_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import lrln_pkg::*;

  // min_range register
  pix_t min_range_q, min_range_d;
  logic cfg_wr;

  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite && (paddr == ADDR_MIN_RANGE);
  assign min_range_d = pwdata[PIXEL_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_range_q <= MIN_RANGE_RESET;
    end else if (cfg_wr) begin
      min_range_q <= min_range_d;
    end
  end

  assign prdata = (paddr == ADDR_MIN_RANGE) ?
                  {{(CFG_DATA_W-PIXEL_BITS){1'b0}}, min_range_q} : '0;

  // unpack the input transfer
  pix_in_t in_data;

  assign in_data.luma    = s_axis_tdata[PIXEL_BITS-1:0];
  assign in_data.env_max = s_axis_tdata[2*PIXEL_BITS-1:PIXEL_BITS];
  assign in_data.env_min = s_axis_tdata[3*PIXEL_BITS-1:2*PIXEL_BITS];
  assign in_data.middle  = s_axis_tdata[4*PIXEL_BITS-1:3*PIXEL_BITS];

  // divider chain handshakes
  logic [DIV_STAGES:0] dv_valid, dv_ready;
  div_t                dv_data [DIV_STAGES+1];
  logic                out_ready;

  lrln_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .min_range_i (min_range_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (in_data),
    .out_valid_o (dv_valid[0]),
    .out_ready_i (dv_ready[0]),
    .out_data_o  (dv_data[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    lrln_div_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (dv_valid[g]),
      .in_ready_o  (dv_ready[g]),
      .in_data_i   (dv_data[g]),
      .out_valid_o (dv_valid[g+1]),
      .out_ready_i (dv_ready[g+1]),
      .out_data_o  (dv_data[g+1])
    );
  end

  // final luma and clip flag from the result kind
  pix_out_t res_d, res_q;
  logic     m_valid_q;

  always_comb begin
    case (dv_data[DIV_STAGES].kind)
      RES_QUOT: begin
        res_d.luma_out = dv_data[DIV_STAGES].work;
        res_d.clipped  = 1'b0;
      end
      RES_FULL: begin
        res_d.luma_out = FULL_SCALE;
        res_d.clipped  = 1'b1;
      end
      default: begin
        res_d.luma_out = '0;
        res_d.clipped  = 1'b0;
      end
    endcase
  end

  // output register
  assign out_ready            = !m_valid_q || m_axis_tready;
  assign dv_ready[DIV_STAGES] = out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_ready) begin
      m_valid_q <= dv_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) res_q <= res_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-PIXEL_BITS-1){1'b0}}, res_q.clipped, res_q.luma_out};

endmodule

`default_nettype wire

// ===== sv/lrln_checker.sv =====
// ----------------------------------------------------------------------------
// lrln_checker
// Port-level checks of the luma normalizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "local_range_luma_normalizer_top_defines.svh"

module lrln_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [lrln_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             psel,
  input logic                             penable,
  input logic                             pwrite,
  input logic [lrln_pkg::CFG_ADDR_W-1:0]  paddr,
  input logic [lrln_pkg::CFG_DATA_W-1:0]  pwdata,
  input logic [lrln_pkg::CFG_DATA_W-1:0]  prdata,
  input logic                             pready
);
  import lrln_pkg::*;

  logic                  cfg_write;
  logic                  cfg_read0;
  logic                  out_clip;
  logic [PIXEL_BITS-1:0] out_luma;
  logic [PIXEL_BITS-1:0] rd_value;
  logic [PIXEL_BITS-1:0] wr_value;

  assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_MIN_RANGE);
  assign cfg_read0 = psel && !pwrite && (paddr == ADDR_MIN_RANGE);
  assign out_clip  = m_axis_tdata[PIXEL_BITS];
  assign out_luma  = m_axis_tdata[PIXEL_BITS-1:0];
  assign rd_value  = prdata[PIXEL_BITS-1:0];
  assign wr_value  = pwdata[PIXEL_BITS-1:0];

  // a stalled result holds
  `LRLN_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, m_axis_tvalid, m_axis_tready, m_axis_tdata)

  // a clipped pixel always reads full scale
  `LRLN_ASSERT(a_clip_full, clk_i, rst_ni, m_axis_tvalid && out_clip |-> out_luma == FULL_SCALE)

  // with no result waiting the whole pipeline can take a pixel
  `LRLN_ASSERT(a_empty_ready, clk_i, rst_ni, !m_axis_tvalid |-> s_axis_tready)

  // min_range reads back the value just written
  `LRLN_ASSERT(a_cfg_readback, clk_i, rst_ni, cfg_read0 && $past(cfg_write) |-> rd_value == $past(wr_value))

  // the padding bits of a result stay zero
  `LRLN_ASSERT(a_out_pad, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:PIXEL_BITS+1] == '0)

endmodule

bind local_range_luma_normalizer_top lrln_checker u_lrln_checker (.*);

`default_nettype wire

// ===== tb/local_range_luma_normalizer_top_test.sv =====
// ----------------------------------------------------------------------------
// local_range_luma_normalizer_top_test
// Self-checking bench for the local range luma normalizer. Pixels go in over
// the input stream and every result transfer is checked against a behavioral
// prediction of envelope mirroring, range widening and luma stretching. The
// min_range register is read back after reset and after every write. Both
// stream sides idle in random bursts, except in the closing full-rate part.
// ----------------------------------------------------------------------------
module local_range_luma_normalizer_top_test;
  import lrln_pkg::*;

  localparam longint FULL           = longint'(FULL_SCALE);
  localparam int     WATCHDOG_LIMIT = 500;
  localparam int     SETTLE_CYCLES  = 16;

  typedef struct packed {
    logic clipped;
    pix_t luma;
  } norm_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [CFG_ADDR_W-1:0]  paddr;
  logic [CFG_DATA_W-1:0]  pwdata;
  logic [CFG_DATA_W-1:0]  prdata;
  logic                   pready;

  // bench state
  norm_result_t expected_pixels[$];
  pix_t         min_span;
  logic         idle_en;
  int           mismatches;
  int           pixels_sent;
  int           pixels_checked;
  int           saturated_seen;
  int           span_settings;

  local_range_luma_normalizer_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // expected stretched luma for one pixel under the given minimum range
  function automatic norm_result_t stretch_luma(input pix_in_t px, input pix_t span_floor);
    longint top, bot, mid, skew, span, centre, diff, quot, floor_v;
    norm_result_t r;
    top     = longint'(px.env_max);
    bot     = longint'(px.env_min);
    mid     = longint'(px.middle);
    floor_v = longint'(span_floor);
    // mirror the narrower side of the envelope about the middle
    skew = top + bot - 2 * mid;
    if (skew > 0) begin
      bot = 2 * mid - top;
      if (bot < 0) bot = 0;
    end else if (skew < 0) begin
      top = 2 * mid - bot;
      if (top > FULL) top = FULL;
    end
    span = top - bot;
    if (span < 0) span = 0;
    centre = bot + span / 2;
    // widen a narrow range around its centre, then push it back into range
    if (span < floor_v) begin
      span = floor_v;
      bot  = centre - span / 2;
      top  = centre + span / 2;
      if (bot < 0) begin
        top = top - bot;
        bot = 0;
      end else if (top > FULL) begin
        bot = bot - (top - FULL);
        top = FULL;
      end
    end
    // stretch luma over the range
    diff      = longint'(px.luma) - bot;
    r.clipped = 1'b0;
    if (span == 0) begin
      r.luma    = FULL_SCALE;
      r.clipped = 1'b1;
    end else if (diff <= 0) begin
      r.luma = '0;
    end else begin
      quot = (diff * FULL) / span;
      if (quot > FULL) begin
        r.luma    = FULL_SCALE;
        r.clipped = 1'b1;
      end else begin
        r.luma = pix_t'(quot);
      end
    end
    return r;
  endfunction

  function automatic pix_t clamp_pixel(input int v);
    if (v < 0) return '0;
    if (v > 65535) return FULL_SCALE;
    return pix_t'(v);
  endfunction

  // mostly well-formed envelopes around the luma, the rest fully random
  function automatic pix_in_t random_pixel();
    pix_in_t px;
    int a, b, lo, hi;
    px = {$urandom(), $urandom()};
    if ($urandom_range(0, 3) != 0) begin
      a  = int'($urandom_range(0, 65535));
      if ($urandom_range(0, 1) == 1) b = a + int'($urandom_range(0, 8000));
      else b = int'($urandom_range(0, 65535));
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (hi > 65535) hi = 65535;
      px.env_min = pix_t'(lo);
      px.env_max = pix_t'(hi);
      px.middle  = clamp_pixel((lo + hi) / 2 + int'($urandom_range(0, 4096)) - 2048);
      px.luma    = clamp_pixel(lo + int'($urandom_range(0, hi - lo + 2048)) - 1024);
    end
    return px;
  endfunction

  // one pixel transfer, with an occasional idle burst ahead of it
  task automatic send_pixel(input pix_in_t px);
    int gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_pixels.push_back(stretch_luma(px, min_span));
    pixels_sent++;
  endtask

  task automatic send_fields(input pix_t luma, input pix_t env_max, input pix_t env_min,
                             input pix_t middle);
    pix_in_t px;
    px.luma    = luma;
    px.env_max = env_max;
    px.env_min = env_min;
    px.middle  = middle;
    send_pixel(px);
  endtask

  // stop sending and wait until every result has come back
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // one register port transfer: setup cycle then access cycle
  task automatic reg_transfer(input logic wr, input logic [CFG_DATA_W-1:0] wdata,
                              output logic [CFG_DATA_W-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_MIN_RANGE;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    if (wr) min_span = wdata[PIXEL_BITS-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_min_range_readback();
    logic [CFG_DATA_W-1:0] rd;
    reg_transfer(1'b0, '0, rd);
    if (rd !== CFG_DATA_W'(min_span)) begin
      $display("%0t: min_range readback expected %0d got %0d", $time, min_span, rd);
      mismatches++;
    end
  endtask

  task automatic set_min_range(input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] rd;
    drain_results();
    reg_transfer(1'b1, value, rd);
    span_settings++;
    check_min_range_readback();
  endtask

  // reset value, then a write with upper bits set that must be dropped
  task automatic test_register_access();
    check_min_range_readback();
    set_min_range(32'hffff_1234);
    set_min_range(CFG_DATA_W'(MIN_RANGE_RESET));
  endtask

  // corner pixels under the reset minimum range
  task automatic test_directed_pixels();
    send_fields(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_fields(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    // luma below the range, above it, and on each edge
    send_fields(16'd100,   16'd40000, 16'd20000, 16'd30000);
    send_fields(16'hffff,  16'd40000, 16'd20000, 16'd30000);
    send_fields(16'd20000, 16'd40000, 16'd20000, 16'd30000);
    send_fields(16'd40000, 16'd40000, 16'd20000, 16'd30000);
    // mirrored sides: lower clamped, upper not clamped, lower clamped
    send_fields(16'd30000, 16'd60000, 16'd50000, 16'd1000);
    send_fields(16'd30000, 16'd50000, 16'd10000, 16'd35000);
    send_fields(16'hffff,  16'hffff,  16'h0000,  16'h0000);
    // mirrored sides: upper clamped, lower not clamped, upper clamped
    send_fields(16'd500,   16'd200,   16'd100,   16'd65000);
    send_fields(16'd30000, 16'd50000, 16'd10000, 16'd25000);
    send_fields(16'h0000,  16'h0000,  16'h0000,  16'hffff);
    // inverted envelopes
    send_fields(16'd200,   16'd100,   16'd300,   16'd200);
    send_fields(16'hffff,  16'h0000,  16'hffff,  16'h7fff);
    // narrow ranges widened against the bottom and the top
    send_fields(16'd10,    16'd20,    16'd0,     16'd10);
    send_fields(16'd65530, 16'hffff,  16'd65500, 16'd65517);
    // range exactly min_range, and one short of it
    send_fields(16'd3000,  16'd6553,  16'd0,     16'd3276);
    send_fields(16'd1000,  16'd10551, 16'd4000,  16'd7275);
    // alternating bit patterns
    send_fields(16'h5555,  16'haaaa,  16'h5555,  16'h8000);
    send_fields(16'haaaa,  16'haaaa,  16'h5555,  16'h7fff);
  endtask

  // largest, smallest, zero and odd minimum ranges
  task automatic test_min_range_extremes();
    set_min_range(32'hffff_ffff);
    send_fields(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_fields(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_fields(16'h8000, 16'd36000, 16'd28000, 16'h8000);
    set_min_range(32'd1);
    send_fields(16'd100, 16'd100, 16'd100, 16'd100);
    send_fields(16'd101, 16'd100, 16'd100, 16'd100);
    send_fields(16'd102, 16'd100, 16'd100, 16'd100);
    // zero range is only reachable with a zero minimum
    set_min_range(32'd0);
    send_fields(16'd100,  16'd100, 16'd100, 16'd100);
    send_fields(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_fields(16'd5,    16'd300, 16'd100, 16'd200);
    set_min_range(32'h5a5a_0007);
    send_fields(16'd50,  16'd52,  16'd50,  16'd51);
    send_fields(16'd4,   16'd2,   16'd0,   16'd1);
    send_fields(16'hfffe, 16'hffff, 16'hfffd, 16'hfffe);
  endtask

  // random pixels over a series of minimum ranges
  task automatic test_random_pixels();
    logic [CFG_DATA_W-1:0] spans[8];
    spans[0] = CFG_DATA_W'(MIN_RANGE_RESET);
    spans[1] = 32'd1;
    spans[2] = 32'd65535;
    spans[3] = $urandom_range(1, 65535) | 32'd1;
    spans[4] = $urandom_range(1, 2000);
    spans[5] = $urandom_range(30000, 65535);
    spans[6] = $urandom();
    spans[7] = 32'd0;
    foreach (spans[i]) begin
      set_min_range(spans[i]);
      repeat (i == 7 ? 40 : 150) send_pixel(random_pixel());
    end
  endtask

  // closing part at full rate on both sides
  task automatic test_full_rate();
    set_min_range($urandom_range(1, 65535));
    idle_en = 1'b0;
    repeat (200) send_pixel(random_pixel());
  endtask

  // result stall bursts
  initial begin : result_backpressure
    int stall;
    stall         = 0;
    m_axis_tready = 1'b1;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else if (idle_en && $urandom_range(0, 11) == 0) begin
        stall = $urandom_range(0, 17);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    norm_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result luma %0d clipped %0d", $time,
                 m_axis_tdata[PIXEL_BITS-1:0], m_axis_tdata[PIXEL_BITS]);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (want.clipped) saturated_seen++;
        if (m_axis_tdata[PIXEL_BITS-1:0] !== want.luma) begin
          $display("%0t: luma_out expected %0d got %0d", $time, want.luma,
                   m_axis_tdata[PIXEL_BITS-1:0]);
          mismatches++;
        end
        if (m_axis_tdata[PIXEL_BITS] !== want.clipped) begin
          $display("%0t: clipped expected %0d got %0d", $time, want.clipped,
                   m_axis_tdata[PIXEL_BITS]);
          mismatches++;
        end
      end
    end
  end

  // end the run when nothing moves for too long
  initial begin : stall_watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || psel || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
             WATCHDOG_LIMIT, expected_pixels.size());
    $display("Regression FAIL");
    $finish;
  end

  // test sequence
  initial begin : regression
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    idle_en        = 1'b1;
    min_span       = MIN_RANGE_RESET;
    mismatches     = 0;
    pixels_sent    = 0;
    pixels_checked = 0;
    saturated_seen = 0;
    span_settings  = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_register_access();
    test_directed_pixels();
    test_min_range_extremes();
    test_random_pixels();
    test_full_rate();
    drain_results();

    $display("checked %0d of %0d pixels over %0d min_range writes, %0d clipped",
             pixels_checked, pixels_sent, span_settings, saturated_seen);
    $display("mirroring, widening, zero range and saturation exercised with stalls");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/lrln_pkg.sv
sv/lrln_prep.sv
sv/lrln_div_stage.sv
sv/local_range_luma_normalizer_top.sv
sv/lrln_checker.sv
tb/local_range_luma_normalizer_top_test.sv
